[rtl/sha256_pkg.sv]
// Shared types, constants and round functions of the SHA-256 engine.
// Used by sha256_ctrl, sha256_dp and sha256_hash_engine_core; no dependencies.
package sha256_pkg;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned Rounds     = 64;
  localparam int unsigned HashWords  = 8;

  localparam logic [7:0] PadMark = 8'h80;
  localparam logic [5:0] LenStart = 6'd56;
  localparam logic [5:0] FillLast = 6'd63;
  localparam logic [5:0] RoundLast = 6'd63;
  localparam logic [2:0] WordLast = 3'd7;

  localparam logic [31:0] ROUND_K [0:63] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] HASH_IV [0:7] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_UPDATE,
    ST_PAD,
    ST_LEN,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    SRC_MSG,
    SRC_MARK,
    SRC_ZERO,
    SRC_LEN
  } byte_src_t;

  typedef struct packed {
    logic       byte_en;
    byte_src_t  byte_src;
    logic       vars_load;
    logic       round_en;
    logic [5:0] round;
    logic       hash_add;
    logic       clear;
    logic [2:0] word_sel;
  } cmd_t;

  typedef struct packed {
    logic [5:0] fill;
  } status_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

[rtl/sha256_dp.sv]
// Datapath of the SHA-256 engine: block shift line, message schedule window,
// working variables, hash state, fill and bit counters. Depends on sha256_pkg.
module sha256_dp (
  input  logic                clk,
  input  logic                rst,
  input  sha256_pkg::cmd_t    cmd,
  input  logic [7:0]          msg_byte,
  output sha256_pkg::status_t status,
  output logic [31:0]         digest_word
);
  import sha256_pkg::*;

  logic [511:0] blk;
  logic [31:0]  hash [0:7];
  logic [31:0]  vars [0:7];
  logic [5:0]   fill;
  logic [63:0]  bit_count;

  logic [7:0]   byte_in;
  logic [2:0]   len_lane;
  logic [31:0]  w0, w1, w9, w14, w_new;
  logic [31:0]  t1, t2, choose, major;

  assign len_lane = ~fill[2:0];
  assign w0  = blk[511:480];
  assign w1  = blk[479:448];
  assign w9  = blk[223:192];
  assign w14 = blk[63:32];

  always_comb begin
    unique case (cmd.byte_src)
      SRC_MSG:  byte_in = msg_byte;
      SRC_MARK: byte_in = PadMark;
      SRC_ZERO: byte_in = 8'h00;
      SRC_LEN:  byte_in = bit_count[{len_lane, 3'b000} +: 8];
      default:  byte_in = 8'h00;
    endcase
  end

  assign w_new  = small_sigma1(w14) + w9 + small_sigma0(w1) + w0;
  assign choose = (vars[4] & vars[5]) ^ (~vars[4] & vars[6]);
  assign major  = (vars[0] & vars[1]) ^ (vars[0] & vars[2]) ^ (vars[1] & vars[2]);
  assign t1     = vars[7] + big_sigma1(vars[4]) + choose + ROUND_K[cmd.round] + w0;
  assign t2     = big_sigma0(vars[0]) + major;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      bit_count <= '0;
      for (int i = 0; i < HashWords; i++) hash[i] <= HASH_IV[i];
    end else begin
      if (cmd.clear) begin
        fill      <= '0;
        bit_count <= '0;
        for (int i = 0; i < HashWords; i++) hash[i] <= HASH_IV[i];
      end else begin
        if (cmd.byte_en) begin
          fill <= fill + 6'd1;
          if (cmd.byte_src == SRC_MSG) bit_count <= bit_count + 64'd8;
        end
        if (cmd.hash_add) begin
          for (int i = 0; i < HashWords; i++) hash[i] <= hash[i] + vars[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.byte_en) begin
      blk <= {blk[503:0], byte_in};
    end else if (cmd.round_en) begin
      blk <= {blk[479:0], w_new};
    end
    if (cmd.vars_load) begin
      for (int i = 0; i < HashWords; i++) vars[i] <= hash[i];
    end else if (cmd.round_en) begin
      vars[7] <= vars[6];
      vars[6] <= vars[5];
      vars[5] <= vars[4];
      vars[4] <= vars[3] + t1;
      vars[3] <= vars[2];
      vars[2] <= vars[1];
      vars[1] <= vars[0];
      vars[0] <= t1 + t2;
    end
  end

  assign status.fill = fill;
  assign digest_word = hash[cmd.word_sel];

endmodule

[rtl/sha256_ctrl.sv]
// Controller of the SHA-256 engine: request intake, padding sequence, round
// count and digest word output. Depends on sha256_pkg; drives sha256_dp.
module sha256_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                byte_present,
  input  logic                end_of_message,
  output logic                out_valid,
  input  logic                out_ready,
  input  sha256_pkg::status_t status,
  output sha256_pkg::cmd_t    cmd
);
  import sha256_pkg::*;

  state_t     state, state_next;
  logic [5:0] round;
  logic [2:0] word;
  logic       fin;
  logic       mark_done;
  logic       len_done;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (byte_present && status.fill == FillLast) state_next = ST_LOAD;
          else if (end_of_message)                      state_next = ST_PAD;
        end
      end
      ST_LOAD:  state_next = ST_ROUND;
      ST_ROUND: if (round == RoundLast) state_next = ST_UPDATE;
      ST_UPDATE: begin
        if (!fin)          state_next = ST_IDLE;
        else if (len_done) state_next = ST_OUT;
        else               state_next = ST_PAD;
      end
      ST_PAD: begin
        if (mark_done && status.fill == LenStart) state_next = ST_LEN;
        else if (status.fill == FillLast)         state_next = ST_LOAD;
      end
      ST_LEN:   if (status.fill == FillLast) state_next = ST_LOAD;
      ST_OUT:   if (out_ready && word == WordLast) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    out_valid     = 1'b0;
    cmd           = '0;
    cmd.byte_src  = SRC_MSG;
    cmd.round     = round;
    cmd.word_sel  = word;
    unique case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.byte_en = in_valid && byte_present;
      end
      ST_LOAD:   cmd.vars_load = 1'b1;
      ST_ROUND:  cmd.round_en  = 1'b1;
      ST_UPDATE: cmd.hash_add  = 1'b1;
      ST_PAD: begin
        cmd.byte_en  = !(mark_done && status.fill == LenStart);
        cmd.byte_src = mark_done ? SRC_ZERO : SRC_MARK;
      end
      ST_LEN: begin
        cmd.byte_en  = 1'b1;
        cmd.byte_src = SRC_LEN;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        cmd.clear = out_ready && word == WordLast;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      round     <= '0;
      word      <= '0;
      fin       <= 1'b0;
      mark_done <= 1'b0;
      len_done  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_LOAD)  round <= '0;
      if (state == ST_ROUND) round <= round + 6'd1;
      if (state == ST_IDLE && in_valid && end_of_message) fin <= 1'b1;
      if (state == ST_PAD && !mark_done) mark_done <= 1'b1;
      if (state == ST_LEN && status.fill == FillLast) len_done <= 1'b1;
      if (state == ST_OUT && out_ready) begin
        word <= word + 3'd1;
        if (word == WordLast) begin
          fin       <= 1'b0;
          mark_done <= 1'b0;
          len_done  <= 1'b0;
        end
      end
    end
  end

  a_out_after_len: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (fin && len_done))
    else $error("digest shown before length block was compressed");

  a_round_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND && round == RoundLast) |=> state == ST_UPDATE)
    else $error("round sequence did not end in hash update");

  a_len_aligned: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LEN) |-> (status.fill[5:3] == LenStart[5:3] && mark_done))
    else $error("length bytes outside final eight block positions");

  a_word_reset: assert property (@(posedge clk) disable iff (rst)
    (state != ST_OUT) |-> word == 3'd0)
    else $error("digest word index not rewound");

endmodule

[rtl/sha256_hash_engine_core.sv]
// Top level of the SHA-256 hash engine: joins sha256_ctrl and sha256_dp.
// Depends on sha256_pkg.
//
//   channel | signals                                       | direction
//   --------+-----------------------------------------------+----------
//   in      | in_valid, in_ready, msg_byte, byte_present,   | request in
//           | end_of_message                                |
//   out     | out_valid, out_ready, digest_word,            | request out
//           | word_number, last_word                        |
//
// A message byte is taken whenever in_ready is high; every 64th byte starts a
// compression (one load, 64 rounds of the shared round unit, one hash update).
// The end request adds padding and length bytes and one or two compressions,
// then eight digest words, one per accepted request.
// Synchronous reset restores the initial hash values and clears all counters.
// in_ready is low while a block pads or compresses or the digest is out;
// out_ready low holds the current digest word.
module sha256_hash_engine_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  msg_byte,
  input  logic        byte_present,
  input  logic        end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_number,
  output logic        last_word
);
  import sha256_pkg::*;

  cmd_t    cmd;
  status_t status;

  sha256_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .byte_present   (byte_present),
    .end_of_message (end_of_message),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .cmd            (cmd)
  );

  sha256_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .msg_byte    (msg_byte),
    .status      (status),
    .digest_word (digest_word)
  );

  assign word_number = cmd.word_sel;
  assign last_word   = (cmd.word_sel == WordLast);

endmodule

[tb/sv/tb_sha256_digest_pkg.sv]
`timescale 1ns / 100ps
// Digest scoreboard for the SHA-256 hash engine testbench: round constants,
// a bit-exact message digest predictor and the queue of expected digest words.
// Self-contained; used by tb_sha256_hash_engine_core.
package tb_sha256_digest_pkg;

  localparam bit [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam bit [31:0] SHA_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam bit [7:0] PAD_BYTE = 8'h80;
  localparam bit [5:0] LEN_ROOM = 6'd56;
  localparam bit [2:0] LAST_NUM = 3'd7;
  localparam int unsigned REPORT_MAX = 10;

  typedef struct packed {
    bit [31:0] word;
    bit [2:0]  num;
    bit        last;
  } digest_entry_t;

  function automatic bit [31:0] ror32(input bit [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  class sha256_digest_scoreboard;
    bit [31:0]     chain[8];
    bit [7:0]      blk[64];
    bit [5:0]      fill;
    bit [63:0]     bit_len;
    digest_entry_t expected_digest_q[$];
    int unsigned   mismatches;
    int unsigned   words_checked;
    int unsigned   messages;

    function new();
      restart_message();
      foreach (blk[k]) blk[k] = '0;
      mismatches = 0;
      words_checked = 0;
      messages = 0;
    endfunction

    function void restart_message();
      foreach (chain[k]) chain[k] = SHA_IV[k];
      fill = '0;
      bit_len = '0;
    endfunction

    function void fold_block();
      bit [31:0] w[16];
      bit [31:0] v[8];
      bit [31:0] wr, w15, w2, s0, s1, t1, t2;
      for (int k = 0; k < 16; k++) begin
        w[k] = {blk[4*k], blk[4*k+1], blk[4*k+2], blk[4*k+3]};
      end
      foreach (v[k]) v[k] = chain[k];
      for (int r = 0; r < 64; r++) begin
        if (r < 16) begin
          wr = w[r];
        end else begin
          w15 = w[(r + 1) & 15];
          w2  = w[(r + 14) & 15];
          s0 = ror32(w15, 7) ^ ror32(w15, 18) ^ (w15 >> 3);
          s1 = ror32(w2, 17) ^ ror32(w2, 19) ^ (w2 >> 10);
          wr = w[r & 15] + s0 + w[(r + 9) & 15] + s1;
          w[r & 15] = wr;
        end
        t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25)) +
             ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[r] + wr;
        t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22)) +
             ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6];
        v[6] = v[5];
        v[5] = v[4];
        v[4] = v[3] + t1;
        v[3] = v[2];
        v[2] = v[1];
        v[1] = v[0];
        v[0] = t1 + t2;
      end
      foreach (chain[k]) chain[k] = chain[k] + v[k];
    endfunction

    function void note_request(input bit [7:0] msg_b, input bit present, input bit eom);
      digest_entry_t e;
      if (present) begin
        blk[fill] = msg_b;
        bit_len = bit_len + 64'd8;
        fill = fill + 6'd1;
        if (fill == 6'd0) fold_block();
      end
      if (!eom) return;
      blk[fill] = PAD_BYTE;
      for (int k = int'(fill) + 1; k < 64; k++) blk[k] = '0;
      // no room left for the length: spill into a second block
      if (fill >= LEN_ROOM) begin
        fold_block();
        foreach (blk[k]) blk[k] = '0;
      end
      for (int k = 0; k < 8; k++) blk[63 - k] = bit_len[8*k +: 8];
      fold_block();
      for (int k = 0; k < 8; k++) begin
        e.word = chain[k];
        e.num  = 3'(k);
        e.last = (3'(k) == LAST_NUM);
        expected_digest_q.push_back(e);
      end
      messages++;
      restart_message();
    endfunction

    function void check_word(input bit [31:0] word, input bit [2:0] num, input bit last);
      digest_entry_t e;
      if (expected_digest_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected digest word %h num %0d last %0b", word, num, last);
        return;
      end
      e = expected_digest_q.pop_front();
      words_checked++;
      if (e.word !== word || e.num !== num || e.last !== last) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("digest mismatch: expected word %h num %0d last %0b, got %h %0d %0b",
                   e.word, e.num, e.last, word, num, last);
      end
    endfunction

    function int unsigned pending();
      return expected_digest_q.size();
    endfunction
  endclass

endpackage

[tb/sv/tb_sha256_hash_engine_core.sv]
`timescale 1ns / 100ps
// Top-level testbench of sha256_hash_engine_core: drives byte requests, checks
// every digest word against the scoreboard in tb_sha256_digest_pkg.
module tb_sha256_hash_engine_core;
  import tb_sha256_digest_pkg::*;

  localparam int unsigned ITEM_TARGET  = 320;
  localparam int unsigned QUIET_FROM   = 270;
  localparam int unsigned LONG_HOLD    = 700;
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned DRAIN_CYCLES = 200;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  msg_byte = '0;
  logic        byte_present = 1'b0;
  logic        end_of_message = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] digest_word;
  logic [2:0]  word_number;
  logic        last_word;

  sha256_digest_scoreboard digest_sb = new();

  int unsigned data_requests = 0;
  int unsigned empty_requests = 0;
  int unsigned idle_cycles = 0;
  bit          quiet = 1'b0;
  bit          hold_off_req = 1'b0;
  bit          hold_off_done = 1'b0;
  int unsigned hold_left = 0;

  sha256_hash_engine_core i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .msg_byte       (msg_byte),
    .byte_present   (byte_present),
    .end_of_message (end_of_message),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .digest_word    (digest_word),
    .word_number    (word_number),
    .last_word      (last_word)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) digest_sb.check_word(digest_word, word_number, last_word);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
        $display("tb: failure");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_off_done = 1'b1;
        hold_left = LONG_HOLD - 1;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        hold_left = $urandom_range(1, 18) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // offer one request; entered and left at a falling edge
  task automatic send_request(input bit [7:0] msg_b, input bit present, input bit eom);
    int unsigned gap;
    if (!quiet && $urandom_range(0, 6) == 0) begin
      gap = $urandom_range(1, 18);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    msg_byte <= msg_b;
    byte_present <= present;
    end_of_message <= eom;
    do @(posedge clk); while (!in_ready);
    digest_sb.note_request(msg_b, present, eom);
    if (present || eom) data_requests++;
    else empty_requests++;
    quiet = (data_requests >= QUIET_FROM);
    @(negedge clk);
  endtask

  task automatic send_message(input int unsigned len, input bit end_on_byte, input bit noisy);
    bit eom;
    for (int unsigned i = 0; i < len; i++) begin
      if (noisy && $urandom_range(0, 7) == 0) send_request(8'($urandom), 1'b0, 1'b0);
      eom = end_on_byte && (i == len - 1);
      send_request(8'($urandom), 1'b1, eom);
    end
    if (!end_on_byte || len == 0) send_request(8'($urandom), 1'b0, 1'b1);
  endtask

  initial begin
    int unsigned len;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty message, ignored item, short messages, byte extremes
    send_request(8'h00, 1'b0, 1'b1);
    send_request(8'ha5, 1'b0, 1'b0);
    send_request(8'h61, 1'b1, 1'b0);
    send_request(8'h62, 1'b1, 1'b0);
    send_request(8'h63, 1'b1, 1'b1);
    send_request(8'h00, 1'b1, 1'b0);
    send_request(8'hff, 1'b0, 1'b1);
    send_request(8'hff, 1'b1, 1'b1);
    send_request(8'h55, 1'b1, 1'b0);
    send_request(8'haa, 1'b0, 1'b0);
    send_request(8'h0f, 1'b1, 1'b1);
    send_request(8'h00, 1'b0, 1'b1);
    send_request(8'hff, 1'b0, 1'b1);

    // random messages around the padding and block boundaries
    hold_off_req = 1'b1;
    while (data_requests < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0: len = $urandom_range(0, 3);
        1: len = 55;
        2: len = 56;
        3: len = $urandom_range(63, 64);
        4: len = ($urandom_range(0, 2) == 0) ? $urandom_range(119, 120) : $urandom_range(4, 12);
        default: len = $urandom_range(1, 40);
      endcase
      send_message(len, 1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0);
    end
    in_valid <= 1'b0;

    while (digest_sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d messages, %0d byte/end requests, %0d empty requests",
             digest_sb.messages, data_requests, empty_requests);
    $display("checked %0d digest words, long receiver hold-off %0s, %0d mismatches",
             digest_sb.words_checked, hold_off_done ? "done" : "missed",
             digest_sb.mismatches);
    if (digest_sb.mismatches == 0 && digest_sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
